>>> rtl/core/wcfm_pkg.sv
// shared types and constants for the websocket client frame masker
// no dependencies; imported by every module of the block
package wcfm_pkg;

    localparam int LEN_W      = 63;
    localparam int KEY_W      = 32;
    localparam int BYTE_W     = 8;
    localparam int HDR_MAX    = 14;
    localparam int HDR_IDX_W  = $clog2(HDR_MAX);
    localparam int TDATA_IN_W = 112;

    localparam logic [LEN_W-1:0]  LEN_SHORT_MAX = 63'd125;
    localparam logic [BYTE_W-1:0] LEN_CODE_MID  = 8'd254;
    localparam logic [BYTE_W-1:0] LEN_CODE_LONG = 8'd255;
    localparam logic [BYTE_W-1:0] LEN_MASK_BIT  = 8'd128;

    // extended length byte counts and last header index per length class
    localparam logic [HDR_IDX_W-1:0] EXT_NONE  = 4'd0;
    localparam logic [HDR_IDX_W-1:0] EXT_MID   = 4'd2;
    localparam logic [HDR_IDX_W-1:0] EXT_LONG  = 4'd8;
    localparam logic [HDR_IDX_W-1:0] LAST_SHORT = 4'd5;
    localparam logic [HDR_IDX_W-1:0] LAST_MID   = 4'd7;
    localparam logic [HDR_IDX_W-1:0] LAST_LONG  = 4'd13;

    typedef enum logic
    {
        CMD_START   = 1'b0,
        CMD_PAYLOAD = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        LEN_SHORT = 2'd0,
        LEN_MID   = 2'd1,
        LEN_LONG  = 2'd2
    } len_class_t;

    typedef struct packed
    {
        cmd_t              cmd;
        logic [BYTE_W-1:0] frame_flags;
        logic [LEN_W-1:0]  payload_length;
        logic [KEY_W-1:0]  mask_key;
        logic [BYTE_W-1:0] data_byte;
    } item_t;

    typedef struct packed
    {
        logic [BYTE_W-1:0] out_byte;
        logic              run_last;
        logic              frame_end;
    } result_t;

    // handshake between encoder and its neighbours
    typedef struct packed
    {
        logic push;   // result written to the output register
        logic pop;    // held input item retired
    } enc_ctl_t;

endpackage

>>> rtl/core/websocket_client_frame_masker.sv
// top level of the websocket client frame masker (client-side frame encoder)
// depends on wcfm_pkg, wcfm_in_reg, wcfm_encoder, wcfm_out_reg
//
//  channel   dir  tdata                                  tuser       tlast
//  s_axis    in   flags, length, mask key, data byte     cmd         -
//  m_axis    out  out byte                               frame end   last byte of beat's run
//
// a payload beat gives at most one byte, so payload runs one beat a cycle while m_axis does not stall
// a start beat is held in the input register while its 6, 8 or 14 header bytes go out, one header
//   byte a cycle while m_axis does not stall, paced by the header sequencer in the encoder
// reset clears the frame state (no frame open) and both valid flags
// a stall on m_axis holds the output register; the input register still takes one beat
module websocket_client_frame_masker
    import wcfm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // frame_flags [7:0], payload_length [70:8], mask_key [102:71],
    // data_byte [110:103], zero pad [111]
    input  logic [TDATA_IN_W-1:0] s_axis_tdata,
    // cmd
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // out_byte [7:0]
    output logic [BYTE_W-1:0]     m_axis_tdata,
    output logic                  m_axis_tlast,
    // frame_end
    output logic                  m_axis_tuser
);

    item_t    in_item;
    item_t    held_item;
    logic     held_valid;
    logic     in_load;
    logic     out_free;
    enc_ctl_t ctl;
    result_t  enc_res;
    result_t  out_res;

    // unpack the input beat, lowest field first
    assign in_item.cmd            = cmd_t'(s_axis_tuser);
    assign in_item.frame_flags    = s_axis_tdata[7:0];
    assign in_item.payload_length = s_axis_tdata[70:8];
    assign in_item.mask_key       = s_axis_tdata[102:71];
    assign in_item.data_byte      = s_axis_tdata[110:103];

    // room when empty or when the held item retires this cycle
    assign s_axis_tready = !held_valid || ctl.pop;
    assign in_load       = s_axis_tvalid && s_axis_tready;

    wcfm_in_reg u_in_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_load),
        .load_item (in_item),
        .pop       (ctl.pop),
        .valid     (held_valid),
        .item      (held_item)
    );

    wcfm_encoder u_encoder
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (held_valid),
        .item     (held_item),
        .out_free (out_free),
        .ctl      (ctl),
        .res      (enc_res)
    );

    wcfm_out_reg u_out_reg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (ctl.push),
        .load_res (enc_res),
        .ready    (m_axis_tready),
        .free     (out_free),
        .valid    (m_axis_tvalid),
        .res      (out_res)
    );

    assign m_axis_tdata = out_res.out_byte;
    assign m_axis_tlast = out_res.run_last;
    assign m_axis_tuser = out_res.frame_end;

endmodule

>>> rtl/core/wcfm_in_reg.sv
// input register of the frame masker: holds one accepted beat
// depends on wcfm_pkg
module wcfm_in_reg
    import wcfm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  load,
    input  item_t load_item,
    input  logic  pop,
    output logic  valid,
    output item_t item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= load_item;
        end
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

>>> rtl/core/wcfm_encoder.sv
// frame state, header byte sequencer and payload masking
// depends on wcfm_pkg
module wcfm_encoder
    import wcfm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  item_t    item,
    input  logic     out_free,
    output enc_ctl_t ctl,
    output result_t  res
);

    logic [KEY_W-1:0]     mask_word_reg;
    logic [KEY_W-1:0]     mask_word_next;
    logic [1:0]           byte_position_reg;
    logic [1:0]           byte_position_next;
    logic [LEN_W-1:0]     bytes_left_reg;
    logic [LEN_W-1:0]     bytes_left_next;
    logic [HDR_IDX_W-1:0] hdr_idx_reg;
    logic [HDR_IDX_W-1:0] hdr_idx_next;

    len_class_t           len_class;
    logic [HDR_IDX_W-1:0] ext_len;
    logic [HDR_IDX_W-1:0] last_idx;
    logic [HDR_IDX_W-1:0] ext_idx;
    logic [HDR_IDX_W-1:0] key_idx;
    logic [2:0]           len_sel;
    logic [63:0]          len_wide;
    logic [BYTE_W-1:0]    hdr_byte;
    logic [BYTE_W-1:0]    mask_byte;
    logic                 is_start;
    logic                 hdr_last;
    logic                 drop;
    logic                 push;
    logic                 pop;

    assign is_start = (item.cmd == CMD_START);
    assign len_wide = {1'b0, item.payload_length};

    // length class of the held start item
    always_comb
    begin
        priority if (item.payload_length <= LEN_SHORT_MAX)
        begin
            len_class = LEN_SHORT;
        end
        else if (item.payload_length[LEN_W-1:16] == '0)
        begin
            len_class = LEN_MID;
        end
        else
        begin
            len_class = LEN_LONG;
        end
    end

    always_comb
    begin
        unique case (len_class)
            LEN_SHORT:
            begin
                ext_len  = EXT_NONE;
                last_idx = LAST_SHORT;
            end
            LEN_MID:
            begin
                ext_len  = EXT_MID;
                last_idx = LAST_MID;
            end
            default:
            begin
                ext_len  = EXT_LONG;
                last_idx = LAST_LONG;
            end
        endcase
    end

    assign ext_idx  = hdr_idx_reg - 4'd2;
    assign key_idx  = ext_idx - ext_len;
    assign len_sel  = 3'(ext_len - 4'd1 - ext_idx);
    assign hdr_last = (hdr_idx_reg == last_idx);

    // header byte at the current sequencer position
    always_comb
    begin
        priority if (hdr_idx_reg == 4'd0)
        begin
            hdr_byte = item.frame_flags | 8'd1;
        end
        else if (hdr_idx_reg == 4'd1)
        begin
            unique case (len_class)
                LEN_SHORT: hdr_byte = LEN_MASK_BIT | {1'b0, item.payload_length[6:0]};
                LEN_MID:   hdr_byte = LEN_CODE_MID;
                default:   hdr_byte = LEN_CODE_LONG;
            endcase
        end
        else if (ext_idx < ext_len)
        begin
            hdr_byte = len_wide[{len_sel, 3'b000} +: BYTE_W];
        end
        else
        begin
            hdr_byte = item.mask_key[{~key_idx[1:0], 3'b000} +: BYTE_W];
        end
    end

    assign mask_byte = mask_word_reg[{~byte_position_reg, 3'b000} +: BYTE_W];

    // payload beat outside a frame is swallowed without a result
    assign drop = in_valid && !is_start && (bytes_left_reg == '0);
    assign push = in_valid && !drop && out_free;
    assign pop  = drop || (push && (!is_start || hdr_last));

    always_comb
    begin
        if (is_start)
        begin
            res.out_byte  = hdr_byte;
            res.run_last  = hdr_last;
            res.frame_end = hdr_last && (item.payload_length == '0);
        end
        else
        begin
            res.out_byte  = item.data_byte ^ mask_byte;
            res.run_last  = 1'b1;
            res.frame_end = (bytes_left_reg == 63'd1);
        end
    end

    always_comb
    begin
        mask_word_next     = mask_word_reg;
        byte_position_next = byte_position_reg;
        bytes_left_next    = bytes_left_reg;
        hdr_idx_next       = hdr_idx_reg;
        if (push && is_start)
        begin
            if (hdr_last)
            begin
                hdr_idx_next       = '0;
                mask_word_next     = item.mask_key;
                byte_position_next = 2'd0;
                bytes_left_next    = item.payload_length;
            end
            else
            begin
                hdr_idx_next = hdr_idx_reg + 4'd1;
            end
        end
        else if (push)
        begin
            byte_position_next = byte_position_reg + 2'd1;
            bytes_left_next    = bytes_left_reg - 63'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_word_reg     <= '0;
            byte_position_reg <= '0;
            bytes_left_reg    <= '0;
            hdr_idx_reg       <= '0;
        end
        else
        begin
            mask_word_reg     <= mask_word_next;
            byte_position_reg <= byte_position_next;
            bytes_left_reg    <= bytes_left_next;
            hdr_idx_reg       <= hdr_idx_next;
        end
    end

    assign ctl.push = push;
    assign ctl.pop  = pop;

    // sequencer only leaves zero while a start item is held
    a_hdr_idx_held: assert property (@(posedge clk) disable iff (!rst_n)
        (hdr_idx_reg != 4'd0) |-> (in_valid && is_start))
        else $error("header index busy without a start item");

    a_hdr_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_idx_reg <= LAST_LONG)
        else $error("header index beyond longest header");

    a_frame_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !is_start && res.frame_end) |=> (bytes_left_reg == '0))
        else $error("frame end flagged with payload still owed");

    a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !drop) |-> res.run_last)
        else $error("item retired before its last result");

endmodule

>>> rtl/core/wcfm_out_reg.sv
// output register of the frame masker, holds one result beat
// depends on wcfm_pkg
module wcfm_out_reg
    import wcfm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t load_res,
    input  logic    ready,
    output logic    free,
    output logic    valid,
    output result_t res
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign free = !valid_reg || ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= load_res;
        end
    end

    assign valid = valid_reg;
    assign res   = res_reg;

endmodule
